// ===== hdl/id_range_allocator_with_quarantine_macros.svh =====
// Assertion macros shared by the ID range allocator modules.
`ifndef ID_RANGE_ALLOCATOR_WITH_QUARANTINE_MACROS_SVH
`define ID_RANGE_ALLOCATOR_WITH_QUARANTINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/idra_pkg.sv =====
// Package with the constants, codes and shared types of the ID range allocator.
package idra_pkg;

    localparam int NUM_IDS_DEF = 4096;
    localparam int CW          = 14;

    localparam logic [11:0] BYPASS_BASE_RST  = 12'd3072;
    localparam logic [12:0] BYPASS_COUNT_RST = 13'd1024;
    localparam logic [31:0] TIMEOUT_RST      = 32'd2000;

    localparam logic [1:0] CMD_RESERVE = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    localparam logic [1:0] REG_BYPASS_BASE  = 2'd0;
    localparam logic [1:0] REG_BYPASS_COUNT = 2'd1;
    localparam logic [1:0] REG_TIMEOUT      = 2'd2;

    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_INVALID = 2'd1;
    localparam logic [1:0] RES_BUSY    = 2'd2;
    localparam logic [1:0] RES_GRANT   = 2'd3;

    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_LATCH      = 4'd1;
    localparam logic [3:0] OP_CLR        = 4'd2;
    localparam logic [3:0] OP_SWEEP_INIT = 4'd3;
    localparam logic [3:0] OP_SWEEP      = 4'd4;
    localparam logic [3:0] OP_SCAN_INIT  = 4'd5;
    localparam logic [3:0] OP_SCAN       = 4'd6;
    localparam logic [3:0] OP_MARK_INIT  = 4'd7;
    localparam logic [3:0] OP_MARK       = 4'd8;
    localparam logic [3:0] OP_REL_INIT   = 4'd9;
    localparam logic [3:0] OP_REL        = 4'd10;
    localparam logic [3:0] OP_TICK       = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
        logic [1:0] out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] cmd;
        logic       invalid;
        logic       sweep_done;
        logic       scan_done;
        logic       scan_ok;
        logic       mark_done;
        logic       rel_done;
    } t_dp_stat;

endpackage

// ===== hdl/idra_dp.sv =====
// Datapath of the ID range allocator: bitmaps, stamp memory, counters and result register.
`include "id_range_allocator_with_quarantine_macros.svh"

module idra_dp #(
    parameter int NUM_IDS = idra_pkg::NUM_IDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idra_pkg::t_dp_cmd i_cmd,
    output idra_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [1:0]        i_command,
    input  logic              i_use_bypass,
    input  logic              i_any_base,
    input  logic [11:0]       i_req_base,
    input  logic [12:0]       i_req_count,
    input  logic [12:0]       i_req_align,
    input  logic              i_reuse,
    output logic [1:0]        o_status,
    output logic [11:0]       o_granted_base
);

    localparam int AW = $clog2(NUM_IDS);
    localparam int CW = idra_pkg::CW;
    localparam logic [CW-1:0] NUM_C = CW'(NUM_IDS);

    logic occ_mem   [NUM_IDS];
    logic quar_mem  [NUM_IDS];
    logic [31:0] stamp_mem [NUM_IDS];

    logic [11:0] r_bb;
    logic [12:0] r_bc;
    logic [31:0] r_timeout;
    logic [31:0] r_tick;

    logic [1:0]  r_cmd;
    logic        r_any;
    logic [11:0] r_base;
    logic [12:0] r_count;
    logic [12:0] r_align;
    logic        r_reuse;
    logic [CW-1:0] r_start, r_end, r_rel_end;

    logic [CW-1:0] r_ra, n_ra;
    logic [CW-1:0] r_pa, n_pa;
    logic          r_pv, n_pv;
    logic          r_found, n_found;
    logic [CW-1:0] r_run_start, n_run_start;
    logic [12:0]   r_run_len, n_run_len;
    logic [12:0]   r_left, n_left;

    logic        occ_q, quar_q;
    logic [31:0] stamp_q;

    logic          occ_we, occ_wd, quar_we, quar_wd, stamp_we;
    logic [AW-1:0] occ_wa, quar_wa, stamp_wa;

    logic [12:0]   mask;
    logic          bad_align, named_reuse, expire, aligned;
    logic [CW-1:0] lo_in, start_in, end_in, rel_sum;

    assign mask        = (r_align == 13'd0) ? 13'd0 : r_align - 13'd1;
    assign bad_align   = (r_align != 13'd0) && ((r_align & (r_align - 13'd1)) != 13'd0);
    assign named_reuse = r_reuse && !r_any && (r_count == 13'd1);
    assign expire      = (r_tick - stamp_q) > r_timeout;
    assign aligned     = (r_pa[12:0] & mask) == 13'd0;
    assign lo_in       = i_use_bypass ? CW'(r_bb) : '0;
    assign start_in    = i_any_base ? lo_in : lo_in + CW'(i_req_base);
    assign end_in      = i_use_bypass ? CW'(r_bb) + CW'(r_bc) : NUM_C;
    assign rel_sum     = CW'(r_base) + CW'(r_count);

    // Status back to the controller.
    always_comb begin
        o_stat.clr_done   = (r_ra == NUM_C - CW'(1));
        o_stat.cmd        = r_cmd;
        o_stat.invalid    = (r_count == 13'd0) || (r_end > NUM_C) || bad_align ||
                            ((r_start + CW'(r_count)) > r_end);
        o_stat.sweep_done = (r_ra >= NUM_C) && !r_pv;
        o_stat.scan_done  = r_found || ((r_ra >= r_end) && !r_pv);
        o_stat.scan_ok    = r_found && (r_any || (r_run_start == r_start));
        o_stat.mark_done  = (r_left == 13'd0);
        o_stat.rel_done   = (r_ra >= r_rel_end) && !r_pv;
    end

    // Address walk, run tracking and memory write selection.
    always_comb begin
        n_ra        = r_ra;
        n_pa        = r_ra;
        n_pv        = 1'b0;
        n_found     = r_found;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_left      = r_left;
        occ_we      = 1'b0;
        occ_wd      = 1'b0;
        occ_wa      = r_pa[AW-1:0];
        quar_we     = 1'b0;
        quar_wd     = 1'b0;
        quar_wa     = r_pa[AW-1:0];
        stamp_we    = 1'b0;
        stamp_wa    = r_pa[AW-1:0];
        case (i_cmd.op)
            idra_pkg::OP_LATCH: begin
                // A new transaction forgets the run found for the previous one.
                n_found = 1'b0;
            end
            idra_pkg::OP_CLR: begin
                occ_we  = 1'b1;
                occ_wa  = r_ra[AW-1:0];
                quar_we = 1'b1;
                quar_wa = r_ra[AW-1:0];
                n_ra    = r_ra + CW'(1);
            end
            idra_pkg::OP_SWEEP_INIT: begin
                n_ra = '0;
            end
            idra_pkg::OP_SWEEP: begin
                if (r_ra < NUM_C) begin
                    n_pv = 1'b1;
                    n_ra = r_ra + CW'(1);
                end
                if (r_pv && quar_q && ((named_reuse && r_pa == r_start) || expire)) begin
                    occ_we  = 1'b1;
                    quar_we = 1'b1;
                end
            end
            idra_pkg::OP_SCAN_INIT: begin
                n_ra      = r_start;
                n_found   = 1'b0;
                n_run_len = '0;
            end
            idra_pkg::OP_SCAN: begin
                if (r_ra < r_end && !r_found) begin
                    n_pv = 1'b1;
                    n_ra = r_ra + CW'(1);
                end
                // A run may only open on an aligned free ID; any occupied ID closes it.
                if (r_pv && !r_found) begin
                    if (occ_q) begin
                        n_run_len = '0;
                    end else if (r_run_len == 13'd0) begin
                        if (aligned) begin
                            n_run_start = r_pa;
                            n_run_len   = 13'd1;
                            n_found     = (r_count == 13'd1);
                        end
                    end else begin
                        n_run_len = r_run_len + 13'd1;
                        n_found   = (r_run_len + 13'd1) == r_count;
                    end
                end
            end
            idra_pkg::OP_MARK_INIT: begin
                n_ra   = r_run_start;
                n_left = r_count;
            end
            idra_pkg::OP_MARK: begin
                if (r_left != 13'd0) begin
                    occ_we = 1'b1;
                    occ_wd = 1'b1;
                    occ_wa = r_ra[AW-1:0];
                    n_ra   = r_ra + CW'(1);
                    n_left = r_left - 13'd1;
                end
            end
            idra_pkg::OP_REL_INIT: begin
                n_ra = CW'(r_base);
            end
            idra_pkg::OP_REL: begin
                if (r_ra < r_rel_end) begin
                    n_pv = 1'b1;
                    n_ra = r_ra + CW'(1);
                end
                // An ID already in quarantine keeps its first stamp.
                if (r_pv && !quar_q) begin
                    quar_we  = 1'b1;
                    quar_wd  = 1'b1;
                    stamp_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bb      <= idra_pkg::BYPASS_BASE_RST;
            r_bc      <= idra_pkg::BYPASS_COUNT_RST;
            r_timeout <= idra_pkg::TIMEOUT_RST;
            r_tick    <= '0;
            r_ra      <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
            r_left    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    idra_pkg::REG_BYPASS_BASE:  r_bb      <= i_cfg_data[11:0];
                    idra_pkg::REG_BYPASS_COUNT: r_bc      <= i_cfg_data[12:0];
                    idra_pkg::REG_TIMEOUT:      r_timeout <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == idra_pkg::OP_TICK) begin
                r_tick <= r_tick + 32'd1;
            end
            r_ra    <= n_ra;
            r_pv    <= n_pv;
            r_found <= n_found;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa        <= n_pa;
        r_run_start <= n_run_start;
        r_run_len   <= n_run_len;
        if (i_cmd.op == idra_pkg::OP_LATCH) begin
            r_cmd   <= i_command;
            r_any   <= i_any_base;
            r_base  <= i_req_base;
            r_count <= i_req_count;
            r_align <= i_req_align;
            r_reuse <= i_reuse;
            r_start <= start_in;
            r_end   <= end_in;
        end
        if (i_cmd.op == idra_pkg::OP_REL_INIT) begin
            r_rel_end <= (rel_sum > NUM_C) ? NUM_C : rel_sum;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                idra_pkg::RES_INVALID: o_status <= idra_pkg::ST_INVALID;
                idra_pkg::RES_BUSY:    o_status <= idra_pkg::ST_BUSY;
                default:               o_status <= idra_pkg::ST_OK;
            endcase
            o_granted_base <= (i_cmd.out_kind == idra_pkg::RES_GRANT) ?
                              r_run_start[11:0] : 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        occ_q   <= occ_mem[r_ra[AW-1:0]];
        quar_q  <= quar_mem[r_ra[AW-1:0]];
        stamp_q <= stamp_mem[r_ra[AW-1:0]];
        if (occ_we) begin
            occ_mem[occ_wa] <= occ_wd;
        end
        if (quar_we) begin
            quar_mem[quar_wa] <= quar_wd;
        end
        if (stamp_we) begin
            stamp_mem[stamp_wa] <= r_tick;
        end
    end

    `IDRA_ASSERT_SAME(a_run_aligned, r_found, (r_run_start[12:0] & mask) == 13'd0, "run base not aligned")
    `IDRA_ASSERT_SAME(a_run_in_window, r_found, (r_run_start >= r_start) && (r_run_start < r_end), "run base outside window")

endmodule

// ===== hdl/idra_ctrl.sv =====
// Controller of the ID range allocator: sequences the phases and owns both handshakes.
`include "id_range_allocator_with_quarantine_macros.svh"

module idra_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output idra_pkg::t_dp_cmd  o_cmd,
    input  idra_pkg::t_dp_stat i_stat
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_MARK  = 3'd5;
    localparam logic [2:0] S_REL   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_res, n_res;
    logic       r_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        o_cmd.op       = idra_pkg::OP_NOP;
        o_cmd.out_load = 1'b0;
        o_cmd.out_kind = r_res;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = idra_pkg::OP_CLR;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = idra_pkg::OP_LATCH;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.cmd)
                    idra_pkg::CMD_RESERVE: begin
                        if (i_stat.invalid) begin
                            n_res   = idra_pkg::RES_INVALID;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.op = idra_pkg::OP_SWEEP_INIT;
                            n_state  = S_SWEEP;
                        end
                    end
                    idra_pkg::CMD_RELEASE: begin
                        o_cmd.op = idra_pkg::OP_REL_INIT;
                        n_state  = S_REL;
                    end
                    idra_pkg::CMD_TICK: begin
                        o_cmd.op = idra_pkg::OP_TICK;
                        n_res    = idra_pkg::RES_OK;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_res   = idra_pkg::RES_INVALID;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SWEEP: begin
                o_cmd.op = idra_pkg::OP_SWEEP;
                if (i_stat.sweep_done) begin
                    o_cmd.op = idra_pkg::OP_SCAN_INIT;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.op = idra_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    if (i_stat.scan_ok) begin
                        o_cmd.op = idra_pkg::OP_MARK_INIT;
                        n_state  = S_MARK;
                    end else begin
                        n_res   = idra_pkg::RES_BUSY;
                        n_state = S_DONE;
                    end
                end
            end
            S_MARK: begin
                o_cmd.op = idra_pkg::OP_MARK;
                if (i_stat.mark_done) begin
                    n_res   = idra_pkg::RES_GRANT;
                    n_state = S_DONE;
                end
            end
            S_REL: begin
                o_cmd.op = idra_pkg::OP_REL;
                if (i_stat.rel_done) begin
                    n_res   = idra_pkg::RES_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The result waits here until the output register has room.
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_res       <= idra_pkg::RES_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `IDRA_ASSERT_NEXT(a_accept_to_check, r_state == S_IDLE && i_in_valid, r_state == S_CHECK, "accepted transaction not checked")
    `IDRA_ASSERT_NEXT(a_done_loads, r_state == S_DONE && out_free, r_out_valid && r_state == S_IDLE, "result not presented")

endmodule

// ===== hdl/id_range_allocator_with_quarantine.sv =====
// Top level of the ID range allocator with release quarantine.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------------
//   request  | i_in_valid / o_in_stall    | i_command .. i_reuse
//   result   | o_out_valid / i_out_stall  | o_status, o_granted_base
//   config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One transaction is handled at a time; its duration is set by the walks over the bitmaps.
// A valid reserve runs a full quarantine sweep one ID a cycle, then the run search, and
// then marks the run. After reset a clearing pass over all NUM_IDS IDs runs before the
// first request is taken. A stalled result sits in the output register while the next
// request is accepted.
module id_range_allocator_with_quarantine #(
    parameter int NUM_IDS = idra_pkg::NUM_IDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic        i_use_bypass,
    input  logic        i_any_base,
    input  logic [11:0] i_req_base,
    input  logic [12:0] i_req_count,
    input  logic [12:0] i_req_align,
    input  logic        i_reuse,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_granted_base,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    idra_pkg::t_dp_cmd  dp_cmd;
    idra_pkg::t_dp_stat dp_stat;

    idra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    idra_dp #(
        .NUM_IDS (NUM_IDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_use_bypass   (i_use_bypass),
        .i_any_base     (i_any_base),
        .i_req_base     (i_req_base),
        .i_req_count    (i_req_count),
        .i_req_align    (i_req_align),
        .i_reuse        (i_reuse),
        .o_status       (o_status),
        .o_granted_base (o_granted_base)
    );

endmodule
